// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/fts16_pkg.sv =====
package fts16_pkg;

  localparam int unsigned FloatW = 32;
  localparam int unsigned PcmW = 16;
  localparam logic [14:0] PcmLimit = 15'd32767;

  // Magnitude of a normal input scaled by 32767, two rounding steps, clamped.
  function automatic logic [14:0] convert_normal(input logic [7:0] expo,
                                                 input logic [22:0] mant);
    logic [23:0] sig;
    logic [38:0] prod;
    logic        top;
    logic [24:0] r0;
    logic [23:0] r;
    logic        guard;
    logic        sticky;
    logic        hi;
    logic [9:0]  e2;
    logic [4:0]  sh;
    logic [23:0] q;
    logic [24:0] rem;
    logic [24:0] half;
    logic [24:0] mask;
    sig = {1'b1, mant};
    prod = 39'(sig) * 39'd32767;
    top = prod[38];
    if (top) begin
      guard = prod[14];
      sticky = |prod[13:0];
      r0 = {1'b0, prod[38:15]};
      if (guard && (sticky || prod[15])) r0 = r0 + 25'd1;
    end else begin
      guard = prod[13];
      sticky = |prod[12:0];
      r0 = {1'b0, prod[37:14]};
      if (guard && (sticky || prod[14])) r0 = r0 + 25'd1;
    end
    hi = r0[24];
    r = hi ? r0[24:1] : r0[23:0];
    // e2 = sh + expo - 150 ; sh = 14 + top + hi
    e2 = 10'({2'b0, expo}) + 10'd14 + 10'(top) + 10'(hi) - 10'd150;
    if (!e2[9]) begin
      convert_normal = PcmLimit;
    end else if ($signed(e2) < -10'sd25) begin
      convert_normal = 15'd0;
    end else begin
      // shift of up to 25: remainder and half kept one bit wider than r
      sh = 5'(-e2);
      q = r >> sh;
      mask = (25'd1 << sh) - 25'd1;
      rem = {1'b0, r} & mask;
      half = 25'd1 << (sh - 5'd1);
      if (rem > half || (rem == half && q[0])) q = q + 24'd1;
      convert_normal = (q > 24'(PcmLimit)) ? PcmLimit : q[14:0];
    end
  endfunction

endpackage

// ===== hw/rtl/fts16_core.sv =====
module fts16_core (
  input  logic [fts16_pkg::FloatW-1:0] float_i,
  output logic [fts16_pkg::PcmW-1:0]   pcm_o
);
  logic        neg;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic [14:0] mag;
  logic        neg_eff;

  assign expo = float_i[30:23];
  assign mant = float_i[22:0];

  always_comb begin
    neg = float_i[31];
    neg_eff = neg;
    if (expo == 8'hFF) begin
      mag = fts16_pkg::PcmLimit;
      if (mant != 23'd0) neg_eff = 1'b1;  // NaN
    end else if (expo == 8'h00) begin
      mag = 15'd0;
    end else begin
      mag = fts16_pkg::convert_normal(expo, mant);
    end
  end

  assign pcm_o = neg_eff ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
endmodule

// ===== hw/rtl/float_to_s16_sample_convert_unit.sv =====
// Float32 to PCM16 sample converter.
// Path from input accept to output valid: the input reg, then the result reg.
// Throughput: one word per cycle; ready drops only when both stages are full
// and the output is stalled.
// Reset: rst_ni asynchronous, active low, clears both valid flags.
module float_to_s16_sample_convert_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        float_sample_valid_i,
  output logic        float_sample_ready_o,
  input  logic [31:0] float_sample_i,
  output logic        pcm_sample_valid_o,
  input  logic        pcm_sample_ready_i,
  output logic signed [15:0] pcm_sample_o
);
  logic        in_vld_q;
  logic [31:0] in_q;
  logic        out_vld_q;
  logic [15:0] out_q;
  logic [15:0] conv;
  logic        out_free;
  logic        in_free;

  fts16_core u_core (.float_i(in_q), .pcm_o(conv));

  // Result register takes a word when empty or being drained.
  assign out_free = !out_vld_q || pcm_sample_ready_i;
  // Input register moves forward whenever the result register can take it.
  assign in_free = !in_vld_q || out_free;
  assign float_sample_ready_o = in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_free) in_vld_q <= float_sample_valid_i;
      if (out_free) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && float_sample_valid_i) in_q <= float_sample_i;
    if (out_free && in_vld_q) out_q <= conv;
  end

  assign pcm_sample_valid_o = out_vld_q;
  assign pcm_sample_o = out_q;
endmodule

// ===== hw/rtl/fts16_checker.sv =====
`include "assert_macros.svh"
module fts16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        float_sample_valid_i,
  input logic        float_sample_ready_o,
  input logic        pcm_sample_valid_o,
  input logic        pcm_sample_ready_i,
  input logic [15:0] pcm_sample_o
);
  `ASSERT_ALWAYS(a_never_min, clk_i, rst_ni, !pcm_sample_valid_o || pcm_sample_o != 16'h8000)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, pcm_sample_valid_o && !pcm_sample_ready_i, pcm_sample_valid_o && $stable(pcm_sample_o))
  `ASSERT_ALWAYS(a_ready_free, clk_i, rst_ni, pcm_sample_ready_i |-> float_sample_ready_o)
  `ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, float_sample_valid_i && float_sample_ready_o && pcm_sample_ready_i, ##1 pcm_sample_valid_o)
endmodule

bind float_to_s16_sample_convert_unit fts16_checker u_fts16_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .float_sample_valid_i(float_sample_valid_i),
  .float_sample_ready_o(float_sample_ready_o),
  .pcm_sample_valid_o(pcm_sample_valid_o),
  .pcm_sample_ready_i(pcm_sample_ready_i),
  .pcm_sample_o(pcm_sample_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        float_sample_valid_i = 1'b0;
  logic        float_sample_ready_o;
  logic [31:0] float_sample_i = '0;
  logic        pcm_sample_valid_o;
  logic        pcm_sample_ready_i = 1'b0;
  logic signed [15:0] pcm_sample_o;

  always #2 clk_i = ~clk_i;

  float_to_s16_sample_convert_unit u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .float_sample_valid_i (float_sample_valid_i),
    .float_sample_ready_o (float_sample_ready_o),
    .float_sample_i       (float_sample_i),
    .pcm_sample_valid_o   (pcm_sample_valid_o),
    .pcm_sample_ready_i   (pcm_sample_ready_i),
    .pcm_sample_o         (pcm_sample_o)
  );

  logic [31:0]        pending_floats[$];
  logic signed [15:0] expected_pcm[$];
  int unsigned        errors = 0;
  int unsigned        cycle = 0;
  int unsigned        send_idle_pct = 22;
  int unsigned        recv_idle_pct = 51;
  int unsigned        hold_cycles = 0;
  bit                 stim_done = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle);
    errors++;
  endtask

  // Round right by sh (1..63), ties to even.
  function automatic logic [63:0] round_shift(input logic [63:0] v, input int sh);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q = v >> sh;
    rem = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // Scale by 32767 in single precision, clamp, round to integer.
  function automatic logic signed [15:0] pcm_of_float(input logic [31:0] bits);
    logic        neg;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [63:0] prod;
    logic [63:0] r;
    logic [63:0] q;
    int          sh;
    int          e2;
    int          mag;
    neg = bits[31];
    ex = bits[30:23];
    man = bits[22:0];
    if (ex == 8'hFF) begin
      mag = 32767;
      if (man != 0) neg = 1'b1;  // NaN goes negative full scale
    end else if (ex == 8'h00) begin
      mag = 0;
    end else begin
      prod = {40'd0, 1'b1, man} * 64'd32767;
      sh = prod[38] ? 15 : 14;
      r = round_shift(prod, sh);
      if (r[24]) begin
        r = r >> 1;
        sh++;
      end
      e2 = sh + int'(ex) - 150;
      if (e2 >= 0) mag = 32767;
      else if (e2 < -25) mag = 0;
      else begin
        q = round_shift(r, -e2);
        mag = (q > 64'd32767) ? 32767 : int'(q);
      end
    end
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  // Driver: pops a word when the previous one is taken or nothing is offered.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni) begin
      if (!float_sample_valid_i || float_sample_ready_o) begin
        if (pending_floats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          float_sample_valid_i <= 1'b1;
          float_sample_i <= pending_floats.pop_front();
        end else begin
          float_sample_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (float_sample_valid_i && float_sample_ready_o)
      expected_pcm.push_back(pcm_of_float(float_sample_i));
  end

  // Receiver ready, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      pcm_sample_ready_i <= 1'b0;
    end else begin
      pcm_sample_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && pcm_sample_valid_o && pcm_sample_ready_i) begin
      if (expected_pcm.size() == 0) begin
        report_mismatch("unexpected word", 32'(pcm_sample_o), 32'd0);
      end else if (pcm_sample_o !== expected_pcm[0]) begin
        report_mismatch("pcm_sample", 32'(pcm_sample_o), 32'(expected_pcm[0]));
        void'(expected_pcm.pop_front());
      end else begin
        void'(expected_pcm.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle > 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] rand_float();
    logic [31:0] b;
    b = $urandom();
    case ($urandom_range(9))
      0, 1, 2, 3: b[30:23] = 8'(110 + $urandom_range(16)); // nominal range
      4, 5:       b[30:23] = 8'(95 + $urandom_range(15));  // near rounding edge
      6:          b[30:23] = 8'(127 + $urandom_range(3));  // clamp region
      7:          b[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return b;
  endfunction

  initial begin
    logic [31:0] directed[$];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h7F7F_FFFF,
                 32'hFF7F_FFFF, 32'h3F00_0000, 32'h3880_0000, 32'hB880_0000,
                 32'h3800_0000, 32'h3800_0100, 32'h3F7F_FFFF, 32'h3F80_0001,
                 32'h0080_0000, 32'h3F00_0080, 32'hBF40_0000, 32'h5555_5555,
                 32'hAAAA_AAAA};
    foreach (directed[i]) pending_floats.push_back(directed[i]);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 22 : 0;
      repeat (530) pending_floats.push_back(rand_float());
      if (phase == 2) hold_cycles = 60;  // stall output so the pipe backs up
      while (pending_floats.size() != 0 || float_sample_valid_i) @(posedge clk_i);
    end
    while (expected_pcm.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
